/* sv/eaq_pkg.sv */
// Shared types, constants and arithmetic helpers for the Euler angle to quaternion block.
package eaq_pkg;

	localparam int ROT_W   = 34;
	localparam int LANES   = 5;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = 33;

	localparam logic [3:0] SEQ_XYZ = 4'd0;
	localparam logic [3:0] SEQ_XZY = 4'd1;
	localparam logic [3:0] SEQ_XYX = 4'd2;
	localparam logic [3:0] SEQ_XZX = 4'd3;
	localparam logic [3:0] SEQ_YXZ = 4'd4;
	localparam logic [3:0] SEQ_YZX = 4'd5;
	localparam logic [3:0] SEQ_YXY = 4'd6;
	localparam logic [3:0] SEQ_YZY = 4'd7;
	localparam logic [3:0] SEQ_ZXY = 4'd8;
	localparam logic [3:0] SEQ_ZYX = 4'd9;
	localparam logic [3:0] SEQ_ZXZ = 4'd10;
	localparam logic [3:0] SEQ_ZYZ = 4'd11;

	// CORDIC gain 0.60725293500888 in Q2.30
	localparam logic signed [ROT_W-1:0] START_GAIN = 34'sd652032874;
	localparam logic signed [ROT_W-1:0] PH_HALF_PI = 34'sd1073741824;
	localparam logic signed [ROT_W-1:0] PH_PI      = 34'sd2147483648;

	typedef struct packed {
		logic signed [15:0] angle_first;
		logic signed [15:0] angle_second;
		logic signed [15:0] angle_third;
		logic [3:0]         sequence_req;
	} eaq_in_t;

	typedef struct packed {
		logic signed [15:0] quat_scalar;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} eaq_out_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] x;
		logic signed [ROT_W-1:0] y;
		logic signed [ROT_W-1:0] z;
		logic                    flip;
	} eaq_rot_t;

	// lanes: half angles 0,1,2, then h0+h2 and h0-h2
	typedef struct packed {
		logic [3:0]             seq;
		eaq_rot_t [LANES-1:0]   rot;
	} eaq_cell_t;

	// atan(2^-i), 2^32 is a full turn
	function automatic logic [31:0] eaq_arc(int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10679838;
			7:  r = 32'd5340245;
			8:  r = 32'd2670163;
			9:  r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			24: r = 32'd41;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			28: r = 32'd3;
			29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// fold phase into [-pi/2, pi/2], flip marks a negated result
	function automatic eaq_rot_t eaq_fold(logic [31:0] ph);
		eaq_rot_t r;
		logic signed [ROT_W-1:0] z;
		z = ROT_W'($signed(ph));
		r.x = START_GAIN;
		r.y = '0;
		r.flip = 1'b0;
		if (z > PH_HALF_PI) begin
			z = z - PH_PI;
			r.flip = 1'b1;
		end else if (z < -PH_HALF_PI) begin
			z = z + PH_PI;
			r.flip = 1'b1;
		end
		r.z = z;
		return r;
	endfunction

	// Q2.30 product, round half up
	function automatic logic signed [PROD_W-1:0] eaq_qmul(logic signed [PROD_W-1:0] a,
			logic signed [PROD_W-1:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

	// Q2.30 to Q1.15 with rounding and saturation
	function automatic logic signed [15:0] eaq_q15(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W:0] t;
		logic signed [SUM_W-15:0] r;
		t = (SUM_W+1)'(v) + (SUM_W+1)'(16384);
		r = t[SUM_W:15];
		if (r > (SUM_W-14)'(32767))
			return 16'sd32767;
		if (r < -(SUM_W-14)'(32768))
			return -16'sd32768;
		return r[15:0];
	endfunction

endpackage

/* sv/euler_angles_to_quaternion.sv */
// Input register, CORDIC_STAGES (max 32) cells, two multiply stages, output register.
// Throughput: one request per cycle; the CORDIC cell chain and the two multiply stages
// are fully pipelined and advance together whenever the output register is free or taken.
// A held result stalls the whole pipeline; bubbles do not collapse.
// Reset clears all valid flags; payload registers are not reset.
module euler_angles_to_quaternion import eaq_pkg::*; #(
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  eaq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output eaq_out_t out_data
);

	localparam int N  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int UP = (ANGLE_BITS <= 31) ? (31 - ANGLE_BITS) : 0;
	localparam int DN = (ANGLE_BITS > 31) ? (ANGLE_BITS - 31) : 0;

	function automatic logic [31:0] half_ph(logic [15:0] raw);
		logic [63:0] ext;
		logic signed [ANGLE_BITS-1:0] ang;
		logic signed [63:0] v;
		ext = 64'(raw);
		ang = ext[ANGLE_BITS-1:0];
		v = 64'(ang);
		v = (v <<< UP) >>> DN;
		return v[31:0];
	endfunction

	logic adv;
	logic out_valid_q;
	eaq_out_t out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// prep: half angles, sum/difference, quadrant fold
	logic [31:0] h0, h1, h2;
	eaq_cell_t prep;

	always_comb begin
		h0 = half_ph(in_data.angle_first);
		h1 = half_ph(in_data.angle_second);
		h2 = half_ph(in_data.angle_third);
		prep.seq    = in_data.sequence_req;
		prep.rot[0] = eaq_fold(h0);
		prep.rot[1] = eaq_fold(h1);
		prep.rot[2] = eaq_fold(h2);
		prep.rot[3] = eaq_fold(h0 + h2);
		prep.rot[4] = eaq_fold(h0 - h2);
	end

	logic      cv [0:N];
	eaq_cell_t cd [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv[0] <= 1'b0;
		else if (adv)
			cv[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			cd[0] <= prep;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		eaq_cordic_cell #(.STAGE(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.valid_in (cv[g]),
			.data_in  (cd[g]),
			.valid_q  (cv[g+1]),
			.data_q   (cd[g+1])
		);
	end

	// undo the quadrant fold
	logic signed [PROD_W-1:0] cs [0:LANES-1];
	logic signed [PROD_W-1:0] sn [0:LANES-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (cd[N].rot[l].flip) begin
				cs[l] = PROD_W'(-cd[N].rot[l].x);
				sn[l] = PROD_W'(-cd[N].rot[l].y);
			end else begin
				cs[l] = PROD_W'(cd[N].rot[l].x);
				sn[l] = PROD_W'(cd[N].rot[l].y);
			end
		end
	end

	// first products
	logic v_s2;
	logic [3:0] seq_s2;
	logic signed [PROD_W-1:0] cc01_s2, ss01_s2, sc01_s2, cs01_s2, c2_s2, s2_s2;
	logic signed [PROD_W-1:0] a_s2, b_s2, c_s2, d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= cv[N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seq_s2  <= cd[N].seq;
			cc01_s2 <= eaq_qmul(cs[0], cs[1]);
			ss01_s2 <= eaq_qmul(sn[0], sn[1]);
			sc01_s2 <= eaq_qmul(sn[0], cs[1]);
			cs01_s2 <= eaq_qmul(cs[0], sn[1]);
			c2_s2   <= cs[2];
			s2_s2   <= sn[2];
			a_s2    <= eaq_qmul(cs[1], cs[3]);
			b_s2    <= eaq_qmul(cs[1], sn[3]);
			c_s2    <= eaq_qmul(sn[1], cs[4]);
			d_s2    <= eaq_qmul(sn[1], sn[4]);
		end
	end

	// triple products
	logic v_s3;
	logic [3:0] seq_s3;
	logic signed [PROD_W-1:0] ccc_s3, sss_s3, scc_s3, csc_s3, ccs_s3, ssc_s3, css_s3, scs_s3;
	logic signed [PROD_W-1:0] a_s3, b_s3, c_s3, d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seq_s3 <= seq_s2;
			ccc_s3 <= eaq_qmul(cc01_s2, c2_s2);
			sss_s3 <= eaq_qmul(ss01_s2, s2_s2);
			scc_s3 <= eaq_qmul(sc01_s2, c2_s2);
			csc_s3 <= eaq_qmul(cs01_s2, c2_s2);
			ccs_s3 <= eaq_qmul(cc01_s2, s2_s2);
			ssc_s3 <= eaq_qmul(ss01_s2, c2_s2);
			css_s3 <= eaq_qmul(cs01_s2, s2_s2);
			scs_s3 <= eaq_qmul(sc01_s2, s2_s2);
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			d_s3   <= d_s2;
		end
	end

	// combine per sequence
	logic signed [SUM_W-1:0] ccc, sss, scc, csc, ccs, ssc, css, scs, ta, tb, tc, td;
	logic signed [SUM_W-1:0] w, qx, qy, qz;

	always_comb begin
		ccc = SUM_W'(ccc_s3);
		sss = SUM_W'(sss_s3);
		scc = SUM_W'(scc_s3);
		csc = SUM_W'(csc_s3);
		ccs = SUM_W'(ccs_s3);
		ssc = SUM_W'(ssc_s3);
		css = SUM_W'(css_s3);
		scs = SUM_W'(scs_s3);
		ta  = SUM_W'(a_s3);
		tb  = SUM_W'(b_s3);
		tc  = SUM_W'(c_s3);
		td  = SUM_W'(d_s3);
		w = '0; qx = '0; qy = '0; qz = '0;
		case (seq_s3)
			SEQ_XYZ: begin
				w = ccc - sss; qx = scc + css; qy = csc - scs; qz = ccs + ssc;
			end
			SEQ_XZY: begin
				w = ccc + sss; qx = scc - css; qy = ccs - ssc; qz = csc + scs;
			end
			SEQ_XYX: begin
				w = ta; qx = tb; qy = tc; qz = td;
			end
			SEQ_XZX: begin
				w = ta; qx = tb; qy = -td; qz = tc;
			end
			SEQ_YXZ: begin
				w = ccc + sss; qx = csc + scs; qy = scc - css; qz = ccs - ssc;
			end
			SEQ_YZX: begin
				w = ccc - sss; qx = ccs + ssc; qy = scc + css; qz = csc - scs;
			end
			SEQ_YXY: begin
				w = ta; qx = tc; qy = tb; qz = -td;
			end
			SEQ_YZY: begin
				w = ta; qx = td; qy = tb; qz = tc;
			end
			SEQ_ZXY: begin
				w = ccc - sss; qx = csc - scs; qy = ccs + ssc; qz = scc + css;
			end
			SEQ_ZYX: begin
				w = ccc + sss; qx = ccs - ssc; qy = csc + scs; qz = scc - css;
			end
			SEQ_ZXZ: begin
				w = ta; qx = tc; qy = td; qz = tb;
			end
			SEQ_ZYZ: begin
				w = ta; qx = -td; qy = tc; qz = tb;
			end
			default: begin
				w = '0; qx = '0; qy = '0; qz = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.quat_scalar <= eaq_q15(w);
			out_q.quat_x      <= eaq_q15(qx);
			out_q.quat_y      <= eaq_q15(qy);
			out_q.quat_z      <= eaq_q15(qz);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_bad_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && seq_s3 > SEQ_ZYZ) |=> (out_q == '0))
		else $error("undefined sequence did not give a zero quaternion");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

	a_chain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cv[N] && !adv) |=> cv[N])
		else $error("CORDIC chain moved during stall");
`endif

endmodule

/* sv/eaq_cordic_cell.sv */
// One CORDIC micro-rotation step applied to all five lanes, registered.
module eaq_cordic_cell import eaq_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid_in,
	input  eaq_cell_t data_in,
	output logic      valid_q,
	output eaq_cell_t data_q
);

	localparam logic signed [ROT_W-1:0] ARC = $signed({2'b00, eaq_arc(STAGE)});

	eaq_cell_t nxt;

	always_comb begin
		nxt = data_in;
		for (int l = 0; l < LANES; l++) begin
			if (data_in.rot[l].z >= 0) begin
				nxt.rot[l].x = data_in.rot[l].x - (data_in.rot[l].y >>> STAGE);
				nxt.rot[l].y = data_in.rot[l].y + (data_in.rot[l].x >>> STAGE);
				nxt.rot[l].z = data_in.rot[l].z - ARC;
			end else begin
				nxt.rot[l].x = data_in.rot[l].x + (data_in.rot[l].y >>> STAGE);
				nxt.rot[l].y = data_in.rot[l].y - (data_in.rot[l].x >>> STAGE);
				nxt.rot[l].z = data_in.rot[l].z + ARC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= nxt;
	end

endmodule
